// File: hdl/imf_pkg.sv
// Shared types, constants and tables for the Ising Metropolis spin-flip block.
// Used by imf_ctrl, imf_dpath and ising_metropolis_flip; no dependencies.
package imf_pkg;

	localparam int SIDE      = 64;
	localparam int DRAW_BITS = 16;

	localparam int IDX_W     = $clog2(SIDE);
	localparam int ROW_W     = 6;
	localparam int DRAW_W    = 16;
	localparam int THRESH_W  = 17;
	localparam int ENERGY_W  = 15;
	localparam int MAGNET_W  = 14;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_THRESH_DE4 = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH_DE8 = 1'b1;

	localparam logic [THRESH_W-1:0] THRESH_DE4_RESET = 17'd1200;
	localparam logic [THRESH_W-1:0] THRESH_DE8_RESET = 17'd22;

	localparam logic [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-2 * SIDE * SIDE);
	localparam logic [MAGNET_W-1:0] MAGNET_RESET = MAGNET_W'(SIDE * SIDE);

	localparam logic [DRAW_W-1:0] DRAW_MASK = (DRAW_BITS >= DRAW_W) ? {DRAW_W{1'b1}} :
		DRAW_W'((64'd1 << DRAW_BITS) - 64'd1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [SIDE-1:0]  row_t;
	typedef idx_t mod_tbl_t [1 << ROW_W];

	function automatic mod_tbl_t build_mod_tbl();
		mod_tbl_t tbl;
		for (int i = 0; i < (1 << ROW_W); i++) begin
			tbl[i] = IDX_W'(i % SIDE);
		end
		return tbl;
	endfunction

	localparam mod_tbl_t MOD_TBL = build_mod_tbl();

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_RD_UP  = 6'b000100,
		ST_RD_MID = 6'b001000,
		ST_RD_DN  = 6'b010000,
		ST_EVAL   = 6'b100000
	} state_t;

	typedef struct packed {
		logic load;
		logic sel_up;
		logic sel_mid;
		logic cap_up;
		logic cap_mid;
		logic eval;
		logic clr_we;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic clr_last;
	} status_t;

endpackage

// File: hdl/imf_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module imf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/imf_ctrl.sv
// Sequencer for the spin-flip block: clearing pass, row reads, evaluation.
// Depends on imf_pkg.
module imf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  imf_pkg::status_t status,
	output imf_pkg::cmd_t    cmd
);

	imf_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imf_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			imf_pkg::ST_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (status.clr_last) begin
					state_d = imf_pkg::ST_IDLE;
				end
			end
			imf_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = imf_pkg::ST_RD_UP;
				end
			end
			imf_pkg::ST_RD_UP: begin
				cmd.sel_up = 1'b1;
				state_d    = imf_pkg::ST_RD_MID;
			end
			imf_pkg::ST_RD_MID: begin
				cmd.sel_mid = 1'b1;
				cmd.cap_up  = 1'b1;
				state_d     = imf_pkg::ST_RD_DN;
			end
			imf_pkg::ST_RD_DN: begin
				cmd.cap_mid = 1'b1;
				state_d     = imf_pkg::ST_EVAL;
			end
			imf_pkg::ST_EVAL: begin
				if (status.out_free) begin
					cmd.eval = 1'b1;
					state_d  = imf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = imf_pkg::ST_CLEAR;
			end
		endcase
	end

endmodule

// File: hdl/imf_dpath.sv
// Datapath of the spin-flip block: row-wide lattice memory, neighbor count,
// acceptance test, running totals and result register. Depends on imf_pkg, imf_ram.
module imf_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  imf_pkg::cmd_t                       cmd,
	output imf_pkg::status_t                    status,
	input  logic                                cfg_we,
	input  logic [imf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [imf_pkg::THRESH_W-1:0]        cfg_wdata,
	input  logic                                req_type,
	input  logic [imf_pkg::ROW_W-1:0]           site_row,
	input  logic [imf_pkg::ROW_W-1:0]           site_col,
	input  logic                                spin_value,
	input  logic [imf_pkg::DRAW_W-1:0]          accept_draw,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                accepted,
	output logic signed [imf_pkg::ENERGY_W-1:0] energy,
	output logic signed [imf_pkg::MAGNET_W-1:0] magnetization
);

	logic [imf_pkg::THRESH_W-1:0] thresh_de4_q, thresh_de8_q;
	logic [imf_pkg::ENERGY_W-1:0] energy_q;
	logic [imf_pkg::MAGNET_W-1:0] magnet_q;
	logic                         out_valid_q, accepted_q;
	imf_pkg::idx_t                clr_q;

	logic                         req_q, want_q;
	imf_pkg::idx_t                r_q, c_q;
	logic [imf_pkg::DRAW_W-1:0]   draw_q;
	imf_pkg::row_t                up_q, mid_q;

	imf_pkg::idx_t                rup, rdn, clf, crt, raddr, waddr;
	imf_pkg::row_t                rdata, wdata;
	logic                         we, s_bit, flip;
	logic [2:0]                   same_cnt;
	logic [imf_pkg::ENERGY_W-1:0] de;
	logic [imf_pkg::MAGNET_W-1:0] mag_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_de4_q <= imf_pkg::THRESH_DE4_RESET;
			thresh_de8_q <= imf_pkg::THRESH_DE8_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				imf_pkg::REG_THRESH_DE4: thresh_de4_q <= cfg_wdata;
				imf_pkg::REG_THRESH_DE8: thresh_de8_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_we) begin
			clr_q <= clr_q + imf_pkg::IDX_W'(1);
		end
	end

	assign status.clr_last = (clr_q == imf_pkg::IDX_W'(imf_pkg::SIDE - 1));
	assign status.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_type;
			want_q <= spin_value;
			r_q    <= imf_pkg::MOD_TBL[site_row];
			c_q    <= imf_pkg::MOD_TBL[site_col];
			draw_q <= accept_draw & imf_pkg::DRAW_MASK;
		end
		if (cmd.cap_up) begin
			up_q <= rdata;
		end
		if (cmd.cap_mid) begin
			mid_q <= rdata;
		end
	end

	assign rup = (r_q == '0) ? imf_pkg::IDX_W'(imf_pkg::SIDE - 1) : r_q - imf_pkg::IDX_W'(1);
	assign rdn = (r_q == imf_pkg::IDX_W'(imf_pkg::SIDE - 1)) ? '0 : r_q + imf_pkg::IDX_W'(1);
	assign clf = (c_q == '0) ? imf_pkg::IDX_W'(imf_pkg::SIDE - 1) : c_q - imf_pkg::IDX_W'(1);
	assign crt = (c_q == imf_pkg::IDX_W'(imf_pkg::SIDE - 1)) ? '0 : c_q + imf_pkg::IDX_W'(1);

	assign raddr = cmd.sel_up ? rup : (cmd.sel_mid ? r_q : rdn);

	assign s_bit    = mid_q[c_q];
	assign same_cnt = {2'b00, mid_q[clf] == s_bit} + {2'b00, mid_q[crt] == s_bit}
		+ {2'b00, up_q[c_q] == s_bit} + {2'b00, rdata[c_q] == s_bit};

	always_comb begin
		if (req_q) begin
			flip = (s_bit != want_q);
		end else if (same_cnt <= 3'd2) begin
			flip = 1'b1;
		end else if (same_cnt == 3'd3) begin
			flip = ({1'b0, draw_q} < thresh_de4_q);
		end else begin
			flip = ({1'b0, draw_q} < thresh_de8_q);
		end
	end

	assign de       = imf_pkg::ENERGY_W'({same_cnt, 2'b00}) - imf_pkg::ENERGY_W'(8);
	assign mag_step = imf_pkg::MAGNET_W'(2);

	assign we    = cmd.clr_we || (cmd.eval && flip);
	assign waddr = cmd.clr_we ? clr_q : r_q;
	assign wdata = cmd.clr_we ? {imf_pkg::SIDE{1'b1}} : (mid_q ^ (imf_pkg::row_t'(1) << c_q));

	imf_ram #(
		.WIDTH(imf_pkg::SIDE),
		.DEPTH(imf_pkg::SIDE)
	) u_lattice (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q    <= imf_pkg::ENERGY_RESET;
			magnet_q    <= imf_pkg::MAGNET_RESET;
			out_valid_q <= 1'b0;
			accepted_q  <= 1'b0;
		end else if (cmd.eval) begin
			out_valid_q <= 1'b1;
			accepted_q  <= flip;
			if (flip) begin
				energy_q <= energy_q + de;
				magnet_q <= s_bit ? magnet_q - mag_step : magnet_q + mag_step;
			end
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign accepted      = accepted_q;
	assign energy        = energy_q;
	assign magnetization = magnet_q;

endmodule

// File: hdl/ising_metropolis_flip.sv
// Top level of the Ising Metropolis spin-flip block.
// Depends on imf_pkg, imf_ctrl, imf_dpath.
//
// Each transaction runs from acceptance through RD_UP, RD_MID, RD_DN and EVAL to its
// result; no new transaction is taken before the last one has left EVAL. The lattice is
// one memory of 64-spin rows with one read and one write port; the rows above, at and
// below the site are read in that order, and EVAL decides the flip and writes it back.
// After reset the block runs a clearing pass over all rows (one row per cycle) that sets
// all spins up; input is stalled during that pass while configuration writes are taken.
// A finished result waits in the output register while the next transaction is taken.
module ising_metropolis_flip (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [imf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [imf_pkg::THRESH_W-1:0]        cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                req_type,
	input  logic [imf_pkg::ROW_W-1:0]           site_row,
	input  logic [imf_pkg::ROW_W-1:0]           site_col,
	input  logic                                spin_value,
	input  logic [imf_pkg::DRAW_W-1:0]          accept_draw,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                accepted,
	output logic signed [imf_pkg::ENERGY_W-1:0] energy,
	output logic signed [imf_pkg::MAGNET_W-1:0] magnetization
);

	imf_pkg::cmd_t    cmd;
	imf_pkg::status_t status;

	imf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status  (status),
		.cmd     (cmd)
	);

	imf_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.req_type     (req_type),
		.site_row     (site_row),
		.site_col     (site_col),
		.spin_value   (spin_value),
		.accept_draw  (accept_draw),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.accepted     (accepted),
		.energy       (energy),
		.magnetization(magnetization)
	);

endmodule
